/* sv/opr_pkg.sv */
// opr_pkg: shared constants and types for the optimal page replacement block
// no dependencies; used by the interfaces, the frame cell and the top level
package opr_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int MAX_REFS_DEF   = 64;

    localparam int PAGE_W     = 8;
    localparam int CFG_W      = 4;
    localparam int IDX_W      = 6;
    localparam int SLOT_OUT_W = 3;
    localparam int FAULT_W    = 7;

    localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

    // control broadcast from the sequencer to every frame cell
    typedef struct packed {
        logic clear_frames;
        logic scan_start;
        logic scan_en;
        logic scan_hit;
        logic any_unseen;
        logic fill_en;
        logic evict_en;
    } opr_ctrl_t;

    // priority chain handed from one cell to the next
    typedef struct packed {
        logic hit;
        logic empty;
        logic unseen;
    } opr_chain_t;

    // per-cell status back to the sequencer
    typedef struct packed {
        logic hit;
        logic empty;
        logic victim;
        logic first;
    } opr_stat_t;

    typedef struct packed {
        logic [IDX_W-1:0]      reference_index;
        logic [PAGE_W-1:0]     referenced_page;
        logic                  was_hit;
        logic [SLOT_OUT_W-1:0] frame_slot;
        logic                  evicted_valid;
        logic [PAGE_W-1:0]     evicted_page;
        logic [FAULT_W-1:0]    fault_total;
        logic                  final_result;
    } opr_result_t;

endpackage

/* sv/opr_request_if.sv */
// opr_request_if: valid/ready channel carrying one reference request
// depends on opr_pkg
interface opr_request_if
    import opr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;

    modport source (output valid, output page_number, output last_reference, input ready);
    modport sink   (input valid, input page_number, input last_reference, output ready);
endinterface

/* sv/opr_result_if.sv */
// opr_result_if: valid/ready channel carrying one replacement result
// depends on opr_pkg
interface opr_result_if
    import opr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [IDX_W-1:0]      reference_index;
    logic [PAGE_W-1:0]     referenced_page;
    logic                  was_hit;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic                  evicted_valid;
    logic [PAGE_W-1:0]     evicted_page;
    logic [FAULT_W-1:0]    fault_total;
    logic                  final_result;

    modport source (
        output valid, output reference_index, output referenced_page, output was_hit,
        output frame_slot, output evicted_valid, output evicted_page, output fault_total,
        output final_result, input ready
    );
    modport sink (
        input valid, input reference_index, input referenced_page, input was_hit,
        input frame_slot, input evicted_valid, input evicted_page, input fault_total,
        input final_result, output ready
    );
endinterface

/* sv/optimal_page_replacement.sv */
// Optimal (farthest next use) page replacement over a loaded reference string.
// Requests are loaded one per cycle into a reference ram; the request marked last starts
// the run, which emits one result per stored reference in order. Each reference passes
// through ram read, fetch and decide in the frame cell row when it hits or fills an
// empty frame; a fault with all frames full adds a scan of the remaining references of
// the string, one per cycle through the single ram read port, and then an evict step.
// No requests are taken while a run is in progress.
// Depends on opr_pkg, opr_request_if, opr_result_if, opr_ram, opr_cell.
module optimal_page_replacement
    import opr_pkg::*;
#(
    parameter int MAX_FRAMES     = MAX_FRAMES_DEF,
    parameter int MAX_REFERENCES = MAX_REFS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    opr_request_if.sink      request,
    opr_result_if.source     result
);
    localparam int ADDR_W = $clog2(MAX_REFERENCES);
    localparam int CNT_W  = $clog2(MAX_REFERENCES + 1);
    localparam int K_W    = $clog2(MAX_FRAMES + 1);
    localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_EVICT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  t_reg, t_next;
    logic              pend_reg, pend_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]  fault_reg, fault_next;
    logic [PAGE_W-1:0] cur_page_reg, cur_page_next;
    logic [CFG_W-1:0]  frames_reg;
    logic              ov_reg, ov_next;
    opr_result_t       res_reg, res_next;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PAGE_W-1:0] ram_rdata;

    logic [PAGE_W-1:0] probe;
    opr_ctrl_t         ctrl;
    opr_chain_t        chain [MAX_FRAMES+1];
    opr_stat_t         stat  [MAX_FRAMES];
    logic [PAGE_W-1:0] cell_page [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] first_vec;

    logic [CFG_W-1:0]  cfg_eff;
    logic [K_W-1:0]    k_eff;
    logic              any_hit, any_empty;
    logic [SLOT_W-1:0] hit_idx, empty_idx, victim_idx;
    logic [PAGE_W-1:0] victim_page;
    logic              slot_free;
    logic              accept;
    logic              is_last;
    logic [CNT_W-1:0]  i_plus;

    logic              emit, advance, miss, evicted;
    logic [SLOT_W-1:0] slot_sel;

    opr_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_REFERENCES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (request.page_number),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign chain[0] = '0;

    for (genvar g = 0; g < MAX_FRAMES; g++)
    begin : g_cell
        opr_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .active    (K_W'(g) < k_reg),
            .probe     (probe),
            .ctrl      (ctrl),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .stat      (stat[g]),
            .page      (cell_page[g])
        );
        assign first_vec[g] = stat[g].first;
    end

    assign any_hit   = chain[MAX_FRAMES].hit;
    assign any_empty = chain[MAX_FRAMES].empty;

    // one-hot selects to frame numbers
    always_comb
    begin
        hit_idx     = '0;
        empty_idx   = '0;
        victim_idx  = '0;
        victim_page = '0;
        for (int f = 0; f < MAX_FRAMES; f++)
        begin
            if (stat[f].hit)
            begin
                hit_idx = hit_idx | SLOT_W'(f);
            end
            if (stat[f].empty)
            begin
                empty_idx = empty_idx | SLOT_W'(f);
            end
            if (stat[f].victim)
            begin
                victim_idx  = victim_idx | SLOT_W'(f);
                victim_page = victim_page | cell_page[f];
            end
        end
    end

    // frame count clamped to 1..MAX_FRAMES
    always_comb
    begin
        cfg_eff = (frames_reg == '0) ? CFG_W'(1) : frames_reg;
        if (32'(cfg_eff) > MAX_FRAMES)
        begin
            k_eff = K_W'(MAX_FRAMES);
        end
        else
        begin
            k_eff = K_W'(cfg_eff);
        end
    end

    assign request.ready = (state_reg == ST_LOAD);
    assign accept        = request.valid && request.ready;
    assign slot_free     = !ov_reg || result.ready;
    assign i_plus        = i_reg + 1'b1;
    assign is_last       = (i_plus == count_reg);
    assign probe         = (state_reg == ST_SCAN) ? ram_rdata : cur_page_reg;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        t_next        = t_reg;
        pend_next     = pend_reg;
        k_next        = k_reg;
        fault_next    = fault_reg;
        cur_page_next = cur_page_reg;
        ov_next       = ov_reg;
        res_next      = res_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = i_reg[ADDR_W-1:0];

        ctrl            = '0;
        ctrl.any_unseen = chain[MAX_FRAMES].unseen;
        ctrl.scan_hit   = |first_vec;

        emit     = 1'b0;
        advance  = 1'b0;
        miss     = 1'b0;
        evicted  = 1'b0;
        slot_sel = hit_idx;

        if (result.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_REFERENCES))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (request.last_reference)
                    begin
                        k_next     = k_eff;
                        i_next     = '0;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cur_page_next = ram_rdata;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (any_hit || any_empty)
                begin
                    if (slot_free)
                    begin
                        emit    = 1'b1;
                        advance = 1'b1;
                        if (!any_hit)
                        begin
                            miss         = 1'b1;
                            slot_sel     = empty_idx;
                            ctrl.fill_en = 1'b1;
                        end
                    end
                end
                else
                begin
                    ctrl.scan_start = 1'b1;
                    t_next          = i_plus;
                    pend_next       = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.scan_en = pend_reg;
                if (t_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = t_reg[ADDR_W-1:0];
                    t_next    = t_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = ST_EVICT;
                    end
                end
            end
            ST_EVICT:
            begin
                if (slot_free)
                begin
                    emit          = 1'b1;
                    advance       = 1'b1;
                    miss          = 1'b1;
                    evicted       = 1'b1;
                    slot_sel      = victim_idx;
                    ctrl.evict_en = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        if (emit)
        begin
            fault_next               = fault_reg + CNT_W'(miss);
            ov_next                  = 1'b1;
            res_next.reference_index = IDX_W'(i_reg);
            res_next.referenced_page = cur_page_reg;
            res_next.was_hit         = !miss;
            res_next.frame_slot      = SLOT_OUT_W'(slot_sel);
            res_next.evicted_valid   = evicted;
            res_next.evicted_page    = evicted ? victim_page : '0;
            res_next.fault_total     = FAULT_W'(fault_next);
            res_next.final_result    = is_last;
        end

        if (advance)
        begin
            if (is_last)
            begin
                count_next        = '0;
                fault_next        = '0;
                ctrl.clear_frames = 1'b1;
                state_next        = ST_LOAD;
            end
            else
            begin
                i_next     = i_plus;
                state_next = ST_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            i_reg      <= '0;
            t_reg      <= '0;
            pend_reg   <= 1'b0;
            k_reg      <= '0;
            fault_reg  <= '0;
            frames_reg <= FRAMES_RESET;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            t_reg     <= t_next;
            pend_reg  <= pend_next;
            k_reg     <= k_next;
            fault_reg <= fault_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                frames_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_page_reg <= cur_page_next;
        res_reg      <= res_next;
    end

    assign result.valid           = ov_reg;
    assign result.reference_index = res_reg.reference_index;
    assign result.referenced_page = res_reg.referenced_page;
    assign result.was_hit         = res_reg.was_hit;
    assign result.frame_slot      = res_reg.frame_slot;
    assign result.evicted_valid   = res_reg.evicted_valid;
    assign result.evicted_page    = res_reg.evicted_page;
    assign result.fault_total     = res_reg.fault_total;
    assign result.final_result    = res_reg.final_result;
endmodule

/* sv/opr_ram.sv */
// opr_ram: generic single write port, single read port ram with registered read
// no dependencies
module opr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* sv/opr_cell.sv */
// opr_cell: one page frame with its next-use tracking for the eviction scan
// depends on opr_pkg; chained by the top level through opr_chain_t
module opr_cell
    import opr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              active,
    input  logic [PAGE_W-1:0] probe,
    input  opr_ctrl_t         ctrl,
    input  opr_chain_t        chain_in,
    output opr_chain_t        chain_out,
    output opr_stat_t         stat,
    output logic [PAGE_W-1:0] page
);
    logic [PAGE_W-1:0] page_reg;
    logic              valid_reg;
    logic              seen_reg;
    logic              last_reg;
    logic              match;
    logic              free;
    logic              unseen;
    logic              write_sel;

    assign match  = active && valid_reg && (page_reg == probe);
    assign free   = active && !valid_reg;
    assign unseen = active && !seen_reg;

    assign chain_out.hit    = chain_in.hit | match;
    assign chain_out.empty  = chain_in.empty | free;
    assign chain_out.unseen = chain_in.unseen | unseen;

    assign stat.hit    = match && !chain_in.hit;
    assign stat.empty  = free && !chain_in.empty;
    assign stat.victim = ctrl.any_unseen ? (unseen && !chain_in.unseen) : last_reg;
    assign stat.first  = match && !seen_reg;

    assign write_sel = (ctrl.fill_en && stat.empty) || (ctrl.evict_en && stat.victim);
    assign page      = page_reg;

    always_ff @(posedge clk)
    begin
        if (write_sel)
        begin
            page_reg <= probe;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            seen_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.clear_frames)
            begin
                valid_reg <= 1'b0;
            end
            else if (write_sel)
            begin
                valid_reg <= 1'b1;
            end

            if (ctrl.scan_start)
            begin
                seen_reg <= 1'b0;
                last_reg <= 1'b0;
            end
            else if (ctrl.scan_en)
            begin
                // first later use of this page: it is now the farthest seen so far
                if (stat.first)
                begin
                    seen_reg <= 1'b1;
                    last_reg <= 1'b1;
                end
                else if (ctrl.scan_hit)
                begin
                    last_reg <= 1'b0;
                end
            end
        end
    end
endmodule
